>>> hdl/lpe_pkg.sv
// Shared constants, codes and types of the line position estimator.
`default_nettype none

package lpe_pkg;

    // Default number of sensor channels.
    localparam int SENSORS_DEFAULT = 12;

    // Item field widths.
    localparam int OP_W   = 2;
    localparam int CH_W   = 4;
    localparam int RAW_W  = 10;
    localparam int NORM_W = 10;
    localparam int POS_W  = 14;
    localparam int WS_W   = 28;
    localparam int NT_W   = 14;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CALIBRATE = 2'd0;
    localparam logic [OP_W-1:0] OP_FINISH    = 2'd1;
    localparam logic [OP_W-1:0] OP_MEASURE   = 2'd2;
    localparam logic [OP_W-1:0] OP_LOAD      = 2'd3;

    // Calibration and normalisation constants.
    localparam logic [RAW_W-1:0] CAL_MIN_RESET   = 10'd1023;
    localparam logic [RAW_W-1:0] CAL_MAX_RESET   = 10'd0;
    localparam logic [RAW_W-1:0] CAL_MIN_DEFAULT = 10'd0;
    localparam logic [RAW_W-1:0] CAL_MAX_DEFAULT = 10'd600;
    localparam int               NORM_FULL       = 1000;

    // Shared divider geometry.
    localparam int DIVIDEND_W = WS_W;
    localparam int DIVISOR_W  = NT_W;
    localparam int STEP_W     = 5;
    localparam int NORM_Q_W   = 20;
    localparam int NORM_PAD   = DIVIDEND_W - NORM_Q_W;

    localparam logic [STEP_W-1:0] NORM_STEPS = STEP_W'(NORM_Q_W);
    localparam logic [STEP_W-1:0] POS_STEPS  = STEP_W'(DIVIDEND_W);

    // Request to the shared divider.
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } lpe_div_req_t;

endpackage

`default_nettype wire

>>> hdl/lpe_divider.sv
// Restoring divider, one quotient bit per cycle, shared by both divisions.
`default_nettype none

module lpe_divider
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire lpe_pkg::lpe_div_req_t        req,
    input  wire logic [lpe_pkg::DIVIDEND_W-1:0] dividend,
    input  wire logic [lpe_pkg::DIVISOR_W-1:0]  divisor,
    output logic                              done,
    output logic [lpe_pkg::DIVIDEND_W-1:0]    quotient
);
    import lpe_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     cnt_reg;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    sub;
    logic                  fits;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_next;

    // One shift-and-subtract step.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        sub      = trial - {1'b0, div_reg};
        fits     = trial >= {1'b0, div_reg};
        rem_next = fits ? sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
    end

    // Control: count the steps and flag the cycle after the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == STEP_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: operands are taken at start, then iterated.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> hdl/line_position_estimator.sv
// Line position estimator top level: calibration tables, sequencer and accumulators.
//
// Usage: items enter on the in_valid/in_stall channel with an operation code,
// a channel index, a raw sample and a min/max pair for loading. Calibrate,
// load and finish items are absorbed in the cycle they are accepted and give
// no result. A measure item on a channel below SENSORS gives exactly one
// result on the out_valid/out_stall channel: the normalised reading and, on
// the last channel, the centroid position with position_valid and line_lost.
// Measure items are worked through by one shared restoring divider: the
// normalisation takes 20 divider steps, and on the last channel, unless the
// normalised readings sum to zero, a second 28-step division forms the
// position. in_stall is high while the item is worked through; one item is
// in flight at a time.
// The result sits in an output register, so the next item is accepted while
// a result waits; a measure item that finishes while the receiver still
// stalls holds in its final step until the register frees.
// Reset (rst_n low, asynchronous) sets every channel minimum to 1023, every
// maximum to 0, clears both accumulators and drops out_valid.
`default_nettype none

module line_position_estimator
#(
    parameter int SENSORS = lpe_pkg::SENSORS_DEFAULT
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [lpe_pkg::OP_W-1:0]       operation,
    input  wire logic [lpe_pkg::CH_W-1:0]       channel,
    input  wire logic [lpe_pkg::RAW_W-1:0]      sample,
    input  wire logic [lpe_pkg::RAW_W-1:0]      load_min,
    input  wire logic [lpe_pkg::RAW_W-1:0]      load_max,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [lpe_pkg::NORM_W-1:0]          norm_value,
    output logic signed [lpe_pkg::POS_W-1:0]    position,
    output logic                                position_valid,
    output logic                                line_lost
);
    import lpe_pkg::*;

    localparam int IDX_W    = $clog2(SENSORS);
    localparam int W_OFFSET = 500 * (SENSORS - 1);
    localparam int POS_LIM  = 500 * (SENSORS - 1);
    localparam int PROD_W   = 26;

    localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(POS_LIM);
    localparam logic signed [POS_W-1:0] POS_MIN = -POS_W'(POS_LIM);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_NSTART = 4'd2;
    localparam logic [3:0] S_NWAIT  = 4'd3;
    localparam logic [3:0] S_NFIN   = 4'd4;
    localparam logic [3:0] S_MUL    = 4'd5;
    localparam logic [3:0] S_ADD    = 4'd6;
    localparam logic [3:0] S_PSTART = 4'd7;
    localparam logic [3:0] S_PWAIT  = 4'd8;
    localparam logic [3:0] S_PFIN   = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;

    // Calibration tables, one entry per channel.
    logic [RAW_W-1:0] min_reg [SENSORS];
    logic [RAW_W-1:0] max_reg [SENSORS];

    logic [3:0]             state_reg;
    logic [3:0]             state_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [RAW_W-1:0]       raw_reg;
    logic [NORM_Q_W-1:0]    num_mag_reg;
    logic [RAW_W-1:0]       dmag_reg;
    logic                   neg_reg;
    logic [NORM_W-1:0]      nv_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [WS_W-1:0]        ws_reg;
    logic [NT_W-1:0]        nt_reg;
    logic                   lost_reg;
    logic [POS_W-1:0]       pos_reg;

    logic                   out_valid_reg;
    logic [NORM_W-1:0]      norm_out_reg;
    logic [POS_W-1:0]       pos_out_reg;
    logic                   pv_out_reg;
    logic                   lost_out_reg;

    logic                   in_accept;
    logic                   ch_ok;
    logic [IDX_W-1:0]       in_idx;
    logic                   is_first;
    logic                   is_last;
    logic                   out_free;

    logic [RAW_W-1:0]       mn;
    logic [RAW_W-1:0]       mx;
    logic                   raw_lt;
    logic                   mx_lt;
    logic [RAW_W-1:0]       diff_mag;
    logic [RAW_W-1:0]       dmag_next;
    logic [NORM_Q_W-1:0]    num_mag_next;

    logic [NORM_W-1:0]      nv_next;
    logic [13:0]            ch_scaled;
    logic signed [14:0]     weight;
    logic [WS_W-1:0]        ws_sum;
    logic [NT_W-1:0]        nt_sum;
    logic [WS_W-1:0]        ws_mag;
    logic [POS_W-1:0]       pos_mag;
    logic [POS_W-1:0]       pos_next;

    lpe_div_req_t           div_req;
    logic [DIVIDEND_W-1:0]  div_dividend;
    logic [DIVISOR_W-1:0]   div_divisor;
    logic                   div_done;
    logic [DIVIDEND_W-1:0]  div_quotient;

    // Input handshake and channel decode.
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign ch_ok     = {1'b0, channel} < (CH_W + 1)'(SENSORS);
    assign in_idx    = channel[IDX_W-1:0];
    assign is_first  = (idx_reg == '0);
    assign is_last   = (idx_reg == IDX_W'(SENSORS - 1));
    assign out_free  = !out_valid_reg || !out_stall;

    // Normalisation operands: magnitudes of (raw - min) and (max - min).
    always_comb
    begin
        mn           = min_reg[idx_reg];
        mx           = max_reg[idx_reg];
        raw_lt       = raw_reg < mn;
        mx_lt        = mx < mn;
        diff_mag     = raw_lt ? (mn - raw_reg) : (raw_reg - mn);
        if (mx == mn)
        begin
            dmag_next = RAW_W'(1);
        end
        else
        begin
            dmag_next = mx_lt ? (mn - mx) : (mx - mn);
        end
        num_mag_next = NORM_Q_W'(diff_mag) * NORM_Q_W'(NORM_FULL);
    end

    // Clamp the normalised quotient; a negative quotient reads as zero.
    always_comb
    begin
        if (neg_reg)
        begin
            nv_next = '0;
        end
        else if (div_quotient > DIVIDEND_W'(NORM_FULL))
        begin
            nv_next = NORM_W'(NORM_FULL);
        end
        else
        begin
            nv_next = div_quotient[NORM_W-1:0];
        end
    end

    // Channel weight and accumulator update.
    always_comb
    begin
        ch_scaled = 14'(idx_reg) * 14'(NORM_FULL);
        weight    = $signed({1'b0, ch_scaled}) - $signed(15'(W_OFFSET));
        ws_sum    = (is_first ? '0 : ws_reg)
                  + {{(WS_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        nt_sum    = (is_first ? '0 : nt_reg) + NT_W'(nv_reg);
    end

    // Position: sign and saturation around the unsigned division.
    always_comb
    begin
        ws_mag = ws_reg[WS_W-1] ? (~ws_reg + WS_W'(1)) : ws_reg;
        if (div_quotient > DIVIDEND_W'(POS_LIM))
        begin
            pos_mag = POS_W'(POS_LIM);
        end
        else
        begin
            pos_mag = div_quotient[POS_W-1:0];
        end
        pos_next = ws_reg[WS_W-1] ? (~pos_mag + POS_W'(1)) : pos_mag;
    end

    // Divider request and operand selection.
    always_comb
    begin
        div_req.start = (state_reg == S_NSTART) || (state_reg == S_PSTART);
        if (state_reg == S_PSTART)
        begin
            div_req.steps = POS_STEPS;
            div_dividend  = ws_mag;
            div_divisor   = nt_reg;
        end
        else
        begin
            div_req.steps = NORM_STEPS;
            div_dividend  = {num_mag_reg, {NORM_PAD{1'b0}}};
            div_divisor   = DIVISOR_W'(dmag_reg);
        end
    end

    lpe_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (operation == OP_MEASURE) && ch_ok)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:   state_next = S_NSTART;
            S_NSTART: state_next = S_NWAIT;
            S_NWAIT:
            begin
                if (div_done)
                begin
                    state_next = S_NFIN;
                end
            end
            S_NFIN:   state_next = S_MUL;
            S_MUL:    state_next = S_ADD;
            S_ADD:
            begin
                if (is_last && (nt_sum != '0))
                begin
                    state_next = S_PSTART;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_PSTART: state_next = S_PWAIT;
            S_PWAIT:
            begin
                if (div_done)
                begin
                    state_next = S_PFIN;
                end
            end
            S_PFIN:   state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Calibration tables: calibrate, finish and load items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SENSORS; i++)
            begin
                min_reg[i] <= CAL_MIN_RESET;
                max_reg[i] <= CAL_MAX_RESET;
            end
        end
        else if (in_accept)
        begin
            unique case (operation)
                OP_CALIBRATE:
                begin
                    if (ch_ok)
                    begin
                        if (sample < min_reg[in_idx])
                        begin
                            min_reg[in_idx] <= sample;
                        end
                        if (sample > max_reg[in_idx])
                        begin
                            max_reg[in_idx] <= sample;
                        end
                    end
                end
                OP_FINISH:
                begin
                    for (int i = 0; i < SENSORS; i++)
                    begin
                        if (max_reg[i] <= min_reg[i])
                        begin
                            min_reg[i] <= CAL_MIN_DEFAULT;
                            max_reg[i] <= CAL_MAX_DEFAULT;
                        end
                    end
                end
                OP_LOAD:
                begin
                    if (ch_ok)
                    begin
                        if (load_max <= load_min)
                        begin
                            min_reg[in_idx] <= CAL_MIN_DEFAULT;
                            max_reg[in_idx] <= CAL_MAX_DEFAULT;
                        end
                        else
                        begin
                            min_reg[in_idx] <= load_min;
                            max_reg[in_idx] <= load_max;
                        end
                    end
                end
                OP_MEASURE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control state, accumulators and the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ws_reg        <= '0;
            nt_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ADD)
            begin
                ws_reg <= ws_sum;
                nt_reg <= nt_sum;
            end
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (is_last)
                begin
                    ws_reg <= '0;
                    nt_reg <= '0;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the item in flight and the output payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            idx_reg <= in_idx;
            raw_reg <= sample;
        end
        if (state_reg == S_PREP)
        begin
            num_mag_reg <= num_mag_next;
            dmag_reg    <= dmag_next;
            neg_reg     <= raw_lt ^ mx_lt;
        end
        if (state_reg == S_NFIN)
        begin
            nv_reg <= nv_next;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= weight * $signed({1'b0, nv_reg});
        end
        if (state_reg == S_ADD)
        begin
            lost_reg <= is_last && (nt_sum == '0);
            pos_reg  <= '0;
        end
        if (state_reg == S_PFIN)
        begin
            pos_reg <= pos_next;
        end
        if ((state_reg == S_OUT) && out_free)
        begin
            norm_out_reg <= nv_reg;
            pos_out_reg  <= pos_reg;
            pv_out_reg   <= is_last;
            lost_out_reg <= lost_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign norm_value     = norm_out_reg;
    assign position       = $signed(pos_out_reg);
    assign position_valid = pv_out_reg;
    assign line_lost      = lost_out_reg;

`ifndef SYNTHESIS
    // A measure item on a real channel keeps the input side stalled next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (operation == OP_MEASURE) && ch_ok) |=> in_stall)
        else $error("measure item did not start the sequencer");

    // The normalised reading never leaves its range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (norm_value <= NORM_W'(NORM_FULL)))
        else $error("normalised reading out of range");

    // Channels other than the last carry no position and no lost flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !position_valid) |-> ((position == '0) && !line_lost))
        else $error("position on a channel other than the last");

    // A lost line reports a zero position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_lost) |-> (position == '0))
        else $error("non-zero position with the line lost");

    // The centroid stays within the outermost channel weights.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && position_valid) |-> ((position <= POS_MAX) && (position >= POS_MIN)))
        else $error("position outside the saturation limits");
`endif

endmodule

`default_nettype wire
